>>> hw/rtl/lsf_pkg.sv
// Shared types and constants for the five-point Laplacian stream filter.
// No dependencies; imported by every module of the block.
package lsf_pkg;

   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_WIDTH  = 1024;

   localparam int CSR_W  = 11;
   localparam int PIX_W  = 16;
   localparam int LAP_W  = 19;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);

   typedef enum logic [0:0] {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] addr_c;
      logic [ROW_W-1:0] addr_d;
   } ls_rd_type;

   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] addr;
      logic [PIX_W-1:0] prev_data;
      logic [PIX_W-1:0] older_data;
   } ls_wr_type;

   typedef struct packed {
      logic [PIX_W-1:0] center;
      logic [PIX_W-1:0] down;
      logic [PIX_W-1:0] left;
   } ls_data_type;

   typedef struct packed {
      logic             has_res;
      logic             is_pix;
      logic             left_ok;
      logic             top;
      logic             bottom;
      logic             frame_end;
      logic [ROW_W-1:0] row;
      logic [PIX_W-1:0] pixel;
   } stage_type;

endpackage

>>> hw/rtl/lsf_line_store.sv
// Line stores for the last two columns, with registered reads.
// Write-first bypass covers a read of the entry written in the same cycle. Uses lsf_pkg.
module lsf_line_store import lsf_pkg::*; (
   input  logic        clock,
   input  ls_rd_type   rd,
   input  ls_wr_type   wr,
   output ls_data_type rdata
);

   logic [PIX_W-1:0] prev_mem  [MAX_HEIGHT];
   logic [PIX_W-1:0] older_mem [MAX_HEIGHT];

   logic [PIX_W-1:0] c_raw_ff;
   logic [PIX_W-1:0] d_raw_ff;
   logic [PIX_W-1:0] l_raw_ff;
   logic             byp_c_ff;
   logic             byp_d_ff;
   logic [PIX_W-1:0] byp_prev_ff;
   logic [PIX_W-1:0] byp_older_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         prev_mem[wr.addr]  <= wr.prev_data;
         older_mem[wr.addr] <= wr.older_data;
      end
      if (rd.en) begin
         c_raw_ff     <= prev_mem[rd.addr_c];
         d_raw_ff     <= prev_mem[rd.addr_d];
         l_raw_ff     <= older_mem[rd.addr_c];
         byp_c_ff     <= wr.en && (wr.addr == rd.addr_c);
         byp_d_ff     <= wr.en && (wr.addr == rd.addr_d);
         byp_prev_ff  <= wr.prev_data;
         byp_older_ff <= wr.older_data;
      end
   end

   assign rdata.center = byp_c_ff ? byp_prev_ff  : c_raw_ff;
   assign rdata.down   = byp_d_ff ? byp_prev_ff  : d_raw_ff;
   assign rdata.left   = byp_c_ff ? byp_older_ff : l_raw_ff;

endmodule

>>> hw/rtl/laplacian_stencil_filter_top.sv
// Top level of the five-point Laplacian stream filter with replicated borders.
// Uses lsf_pkg and lsf_line_store.

// The frame streams in column-major order, row fastest, one beat per clock
// with no bubbles while the output is not stalled; the result for a pixel
// leaves when the pixel to its right is accepted, and image_height drain
// beats flush the last column. The line-store read (two prev-column ports,
// one older-column port) is registered with the request beat, and the
// stencil sum is loaded into the rsp register when the stencil stage advances.
// No clearing pass after reset. Register writes restart the frame position;
// write only while the block is idle.
module laplacian_stencil_filter_top import lsf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic [PIX_W-1:0]        req_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [LAP_W-1:0] rsp_laplacian,
   output logic                    rsp_frame_end,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   logic [WID_W-1:0] wid_ff;
   logic [HGT_W-1:0] hgt_ff;
   logic [WID_W-1:0] wid_in;
   logic [HGT_W-1:0] hgt_in;
   logic [WID_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             drain_ff;

   logic             s2_valid_ff;
   stage_type        s2_ff;
   stage_type        s2_in;
   logic [PIX_W-1:0] above_ff;

   logic                    rsp_valid_ff;
   logic [LAP_W-1:0]        rsp_lap_ff;
   logic                    rsp_fe_ff;

   logic [31:0]      csr_val;
   logic [ROW_W:0]   row_inc;
   logic [WID_W-1:0] col_inc;
   logic             last_row;
   logic             proc;
   logic             accept;
   logic             out_free;
   logic             s2_go;

   ls_rd_type        rd;
   ls_wr_type        wr;
   ls_data_type      rdata;

   logic [PIX_W-1:0] v_left;
   logic [PIX_W-1:0] v_right;
   logic [PIX_W-1:0] v_up;
   logic [PIX_W-1:0] v_down;
   logic [LAP_W-1:0] lap_sum;

   // register clamp to 1..max
   assign csr_val = 32'(csr_wdata);

   always_comb begin
      if (csr_val == 32'd0) begin
         wid_in = WID_W'(1);
         hgt_in = HGT_W'(1);
      end else begin
         wid_in = (csr_val > 32'(MAX_WIDTH))  ? WID_W'(MAX_WIDTH)  : WID_W'(csr_val);
         hgt_in = (csr_val > 32'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : HGT_W'(csr_val);
      end
   end

   // frame position
   assign row_inc  = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign col_inc  = col_ff + WID_W'(1);
   assign last_row = 32'(row_inc) >= 32'(hgt_ff);

   always_comb begin
      proc            = 1'b0;
      s2_in.has_res   = 1'b0;
      s2_in.is_pix    = 1'b0;
      s2_in.left_ok   = 1'b0;
      s2_in.frame_end = 1'b0;
      s2_in.top       = (row_ff == '0);
      s2_in.bottom    = last_row;
      s2_in.row       = row_ff;
      s2_in.pixel     = req_pixel;
      if (!drain_ff) begin
         if (cmd_type'(req_cmd) == CMD_PIXEL) begin
            proc          = 1'b1;
            s2_in.has_res = (col_ff != '0);
            s2_in.is_pix  = 1'b1;
            s2_in.left_ok = (col_ff > WID_W'(1));
         end
      end else if (cmd_type'(req_cmd) == CMD_DRAIN) begin
         proc            = 1'b1;
         s2_in.has_res   = 1'b1;
         s2_in.left_ok   = (wid_ff > WID_W'(1));
         s2_in.frame_end = last_row;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_go     = s2_valid_ff && (!s2_ff.has_res || out_free);
   assign req_ready = !s2_valid_ff || s2_go;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wid_ff   <= WID_W'(MAX_WIDTH);
         hgt_ff   <= HGT_W'(MAX_HEIGHT);
         col_ff   <= '0;
         row_ff   <= '0;
         drain_ff <= 1'b0;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_WIDTH:  wid_ff <= wid_in;
            REG_HEIGHT: hgt_ff <= hgt_in;
            default: begin
            end
         endcase
         col_ff   <= '0;
         row_ff   <= '0;
         drain_ff <= 1'b0;
      end else if (accept && proc) begin
         if (!last_row) begin
            row_ff <= row_inc[ROW_W-1:0];
         end else begin
            row_ff <= '0;
            if (drain_ff) begin
               col_ff   <= '0;
               drain_ff <= 1'b0;
            end else begin
               col_ff <= col_inc;
               if (col_inc >= wid_ff) begin
                  drain_ff <= 1'b1;
               end
            end
         end
      end
   end

   // line-store access
   assign rd.en      = accept && proc;
   assign rd.addr_c  = row_ff;
   assign rd.addr_d  = row_inc[ROW_W-1:0];

   assign wr.en         = s2_go && s2_ff.is_pix;
   assign wr.addr       = s2_ff.row;
   assign wr.prev_data  = s2_ff.pixel;
   assign wr.older_data = rdata.center;

   lsf_line_store u_store (
      .clock (clock),
      .rd    (rd),
      .wr    (wr),
      .rdata (rdata)
   );

   // stencil stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (accept && proc) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_go) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && proc) begin
         s2_ff <= s2_in;
      end
      if (s2_go) begin
         above_ff <= rdata.center;
      end
   end

   assign v_left  = s2_ff.left_ok ? rdata.left : rdata.center;
   assign v_right = s2_ff.is_pix  ? s2_ff.pixel : rdata.center;
   assign v_up    = s2_ff.top     ? rdata.center : above_ff;
   assign v_down  = s2_ff.bottom  ? rdata.center : rdata.down;

   assign lap_sum = (LAP_W'(rdata.center) << 2) - LAP_W'(v_left) - LAP_W'(v_right)
                  - LAP_W'(v_up) - LAP_W'(v_down);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_go && s2_ff.has_res) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go && s2_ff.has_res) begin
         rsp_lap_ff <= lap_sum;
         rsp_fe_ff  <= s2_ff.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_laplacian = $signed(rsp_lap_ff);
   assign rsp_frame_end = rsp_fe_ff;

endmodule

>>> hw/rtl/lsf_checker.sv
// Port-level checks for the Laplacian stream filter, bound to the top level.
// Uses lsf_pkg; attached by the bind statement at the end of this file.
module lsf_port_checks import lsf_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [LAP_W-1:0] rsp_laplacian,
   input logic                    rsp_frame_end
);

   localparam int LAP_MAG = 4 * ((1 << PIX_W) - 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_laplacian)
                                  && $stable(rsp_frame_end))
      else $error("rsp beat dropped or changed while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_lap_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_laplacian >= -LAP_MAG) && (rsp_laplacian <= LAP_MAG))
      else $error("laplacian out of range");

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("rsp beat without a request beat two cycles earlier");

endmodule

bind laplacian_stencil_filter_top lsf_port_checks u_lsf_port_checks (.*);
